/* hw/rtl/mrfb_pkg.sv */
// shared types and constants of the modbus request frame builder
package mrfb_pkg;

  // crc-16 (reflected) as used on modbus rtu links
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // fixed bytes of the write multiple registers frame
  localparam logic [7:0] MULTI_QTY_HI   = 8'h00;
  localparam logic [7:0] MULTI_QTY_LO   = 8'h02;
  localparam logic [7:0] MULTI_BYTE_CNT = 8'h04;

  // frame lengths in bytes, crc included
  localparam int unsigned MULTI_LEN = 13;
  localparam int unsigned SHORT_LEN = 8;

  localparam int unsigned IDX_W = 4;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CODE_WRITE_SINGLE = 3'd0,
    REG_CODE_WRITE_MULTI  = 3'd1,
    REG_CODE_READ_FIRST   = 3'd2,
    REG_CODE_READ_SECOND  = 3'd3,
    REG_READ_QUANTITY     = 3'd4
  } cfg_reg_e;

  // frame layout chosen by the front end
  typedef enum logic [1:0] {
    KIND_SHORT = 2'd0,
    KIND_MULTI = 2'd1,
    KIND_ERR   = 2'd2
  } frame_kind_e;

  typedef struct packed {
    logic [7:0]  code_write_single;
    logic [7:0]  code_write_multi;
    logic [7:0]  code_read_first;
    logic [7:0]  code_read_second;
    logic [15:0] read_quantity;
  } cfg_t;

  // one classified request; short frames carry their payload in data[15:0]
  typedef struct packed {
    frame_kind_e kind;
    logic [7:0]  node_id;
    logic [7:0]  code;
    logic [15:0] reg_addr;
    logic [31:0] data;
  } desc_t;

endpackage

/* hw/rtl/mrfb_cfg.sv */
// apb register file holding the function codes and the read quantity
module mrfb_cfg
  import mrfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_CODE_WRITE_SINGLE: cfg_d.code_write_single = pwdata[7:0];
        REG_CODE_WRITE_MULTI:  cfg_d.code_write_multi  = pwdata[7:0];
        REG_CODE_READ_FIRST:   cfg_d.code_read_first   = pwdata[7:0];
        REG_CODE_READ_SECOND:  cfg_d.code_read_second  = pwdata[7:0];
        REG_READ_QUANTITY:     cfg_d.read_quantity     = pwdata[15:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CODE_WRITE_SINGLE: prdata = {24'd0, cfg_q.code_write_single};
      REG_CODE_WRITE_MULTI:  prdata = {24'd0, cfg_q.code_write_multi};
      REG_CODE_READ_FIRST:   prdata = {24'd0, cfg_q.code_read_first};
      REG_CODE_READ_SECOND:  prdata = {24'd0, cfg_q.code_read_second};
      REG_READ_QUANTITY:     prdata = {16'd0, cfg_q.read_quantity};
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_write_single <= 8'd6;
      cfg_q.code_write_multi  <= 8'd16;
      cfg_q.code_read_first   <= 8'd3;
      cfg_q.code_read_second  <= 8'd4;
      cfg_q.read_quantity     <= 16'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/mrfb_front.sv */
// request intake: matches the function code and builds a frame descriptor
module mrfb_front
  import mrfb_pkg::*;
(
  input  cfg_t        cfg_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [7:0]  req_type_i,
  input  logic [7:0]  node_id_i,
  input  logic [15:0] reg_addr_i,
  input  logic [31:0] value_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output desc_t       q_desc_o
);

  assign req_ready_o = !q_full_i;
  assign q_push_o    = req_valid_i && !q_full_i;

  // priority: write-multi, then either read code, then write-single
  always_comb begin
    q_desc_o.node_id  = node_id_i;
    q_desc_o.code     = req_type_i;
    q_desc_o.reg_addr = reg_addr_i;
    if (req_type_i == cfg_i.code_write_multi) begin
      q_desc_o.kind = KIND_MULTI;
      q_desc_o.data = value_i;
    end else if (req_type_i == cfg_i.code_read_first ||
                 req_type_i == cfg_i.code_read_second) begin
      q_desc_o.kind = KIND_SHORT;
      q_desc_o.data = {16'd0, cfg_i.read_quantity};
    end else if (req_type_i == cfg_i.code_write_single) begin
      q_desc_o.kind = KIND_SHORT;
      q_desc_o.data = {16'd0, value_i[15:0]};
    end else begin
      q_desc_o.kind = KIND_ERR;
      q_desc_o.data = value_i;
    end
  end

endmodule

/* hw/rtl/mrfb_fifo.sv */
// small descriptor queue between intake and byte sequencer
module mrfb_fifo
  import mrfb_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output desc_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  desc_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/mrfb_back.sv */
// byte sequencer: walks the head descriptor, runs the crc, drives the output register
module mrfb_back
  import mrfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  desc_t      q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_bad_o
);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      crc_q, crc_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             bad_q, bad_d;
  logic [IDX_W-1:0] body_len;
  logic [7:0]       body_byte;
  logic             fire;

  assign fire     = !q_empty_i && (!valid_q || out_ready_i);
  assign body_len = (q_head_i.kind == KIND_MULTI) ? IDX_W'(MULTI_LEN - 2)
                                                  : IDX_W'(SHORT_LEN - 2);

  // header and payload bytes by position
  always_comb begin
    case (idx_q)
      4'd0:    body_byte = q_head_i.node_id;
      4'd1:    body_byte = q_head_i.code;
      4'd2:    body_byte = q_head_i.reg_addr[15:8];
      4'd3:    body_byte = q_head_i.reg_addr[7:0];
      4'd4:    body_byte = (q_head_i.kind == KIND_MULTI) ? MULTI_QTY_HI
                                                         : q_head_i.data[15:8];
      4'd5:    body_byte = (q_head_i.kind == KIND_MULTI) ? MULTI_QTY_LO
                                                         : q_head_i.data[7:0];
      4'd6:    body_byte = MULTI_BYTE_CNT;
      4'd7:    body_byte = q_head_i.data[31:24];
      4'd8:    body_byte = q_head_i.data[23:16];
      4'd9:    body_byte = q_head_i.data[15:8];
      4'd10:   body_byte = q_head_i.data[7:0];
      default: body_byte = 8'd0;
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    crc_d   = crc_q;
    q_pop_o = 1'b0;
    byte_d  = byte_q;
    last_d  = last_q;
    bad_d   = bad_q;
    valid_d = valid_q && !out_ready_i;
    if (fire) begin
      valid_d = 1'b1;
      bad_d   = 1'b0;
      last_d  = 1'b0;
      if (q_head_i.kind == KIND_ERR) begin
        byte_d = 8'd0;
        last_d = 1'b1;
        bad_d  = 1'b1;
      end else if (idx_q < body_len) begin
        byte_d = body_byte;
        crc_d  = crc_byte(crc_q, body_byte);
      end else if (idx_q == body_len) begin
        byte_d = crc_q[15:8];
      end else begin
        byte_d = crc_q[7:0];
        last_d = 1'b1;
      end
      if (last_d) begin
        idx_d   = '0;
        crc_d   = CRC_INIT;
        q_pop_o = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      crc_q   <= CRC_INIT;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    bad_q  <= bad_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_bad_o   = bad_q;

endmodule

/* hw/rtl/modbus_request_frame_builder.sv */
// top level of the modbus rtu request frame builder
//
//   channel   dir  handshake                 carries
//   s_axis    in   tvalid / tready           one request (code in tuser)
//   m_axis    out  tvalid / tready           one frame byte, tlast, error flag
//   apb       in   psel / penable / pready   function codes, read quantity
//
// a request becomes 13 bytes (write-multi), 8 bytes (read, write-single) or one
// error byte; with a ready sink bytes leave one per cycle, a request passing the queue, then the output register
// the crc of a body byte is folded in as that byte is registered
// requests queue up while a frame is sent; tready drops only when the queue is full
// a stalled sink holds the output register and, once the queue fills, the intake
// reset is asynchronous, active low, and loads codes 6, 16, 3, 4 and quantity 2
module modbus_request_frame_builder
  import mrfb_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // node_id[7:0], reg_addr[23:8], value[55:24]
  input  logic [7:0]  s_axis_tuser,   // req_type[7:0]
  // frame byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // frame_byte[7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // bad_code[0]
);

  cfg_t  cfg;
  desc_t push_desc;
  desc_t head_desc;
  logic  q_push, q_pop, q_full, q_empty;

  // register file; the user must change codes only while no request is in flight, the block does not enforce it
  mrfb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // intake: layout is decided here so the sequencer only counts bytes
  mrfb_front u_front (
    .cfg_i       (cfg),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .node_id_i   (s_axis_tdata[7:0]),
    .reg_addr_i  (s_axis_tdata[23:8]),
    .value_i     (s_axis_tdata[55:24]),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_desc_o    (push_desc)
  );

  // decouples intake from the byte sequencer
  mrfb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_desc)
  );

  // head descriptor leaves the queue with its last byte
  mrfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_desc),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_bad_o   (m_axis_tuser)
  );

endmodule

/* hw/rtl/mrfb_chk.sv */
// port-level checks of the frame builder, bound to the top level
module mrfb_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // an error item is a lone zero byte that closes its frame
  a_bad_item_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("error item not a zero last byte");

  // a stalled byte stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output byte changed under stall");

  // a full queue means the sequencer has work, so a byte shows next cycle
  a_full_means_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> m_axis_tvalid)
    else $error("request queue full but no byte offered");

endmodule

bind modbus_request_frame_builder mrfb_chk u_mrfb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

/* verif/modbus_request_frame_builder_tb.sv */
// self-checking testbench of the modbus rtu request frame builder
`timescale 1ns / 1ps

module modbus_request_frame_builder_tb
  import mrfb_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  // register slots past the last real register, writes there must be dropped
  localparam logic [2:0] REG_SPARE_A = 3'd5;
  localparam logic [2:0] REG_SPARE_B = 3'd6;
  localparam logic [2:0] REG_SPARE_C = 3'd7;

  // function codes used by the directed tests
  localparam logic [7:0] CODE_MIN         = 8'h00;
  localparam logic [7:0] CODE_MAX         = 8'hFF;
  localparam logic [7:0] CODE_UNUSED      = 8'h05;
  localparam logic [7:0] CODE_SHARED      = 8'h2A;
  localparam logic [7:0] CODE_ALT_MULTI   = 8'h11;
  localparam logic [7:0] CODE_ALT_READ_A  = 8'h33;
  localparam logic [7:0] CODE_ALT_READ_B  = 8'h44;
  localparam logic [7:0] CODE_HIGH_READ   = 8'h80;
  localparam logic [7:0] CODE_LOW_READ    = 8'h7F;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [55:0] s_data = '0;
  logic [7:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;
  logic        m_last;
  logic        m_user;

  cfg_t        shadow_cfg;
  frame_byte_t expected_bytes[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  modbus_request_frame_builder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),   // node_id[7:0], reg_addr[23:8], value[55:24]
    .s_axis_tuser  (s_user),   // req_type[7:0]
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),   // frame_byte[7:0]
    .m_axis_tlast  (m_last),
    .m_axis_tuser  (m_user)    // bad_code[0]
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[modbus_request_frame_builder] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // one byte of crc-16, reflected polynomial, lsb first
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // queue up every frame byte that one request must produce
  function automatic void predict_frame(logic [7:0] code, logic [7:0] id,
                                        logic [15:0] addr, logic [31:0] val);
    logic [7:0]  body [MULTI_LEN];
    frame_kind_e kind;
    int unsigned len;
    logic [15:0] crc;
    body[0] = id;
    body[1] = code;
    body[2] = addr[15:8];
    body[3] = addr[7:0];
    len = SHORT_LEN;
    // multi beats read beats single when codes overlap
    if (code == shadow_cfg.code_write_multi) begin
      kind = KIND_MULTI;
      len = MULTI_LEN;
      body[4] = MULTI_QTY_HI;
      body[5] = MULTI_QTY_LO;
      body[6] = MULTI_BYTE_CNT;
      body[7] = val[31:24];
      body[8] = val[23:16];
      body[9] = val[15:8];
      body[10] = val[7:0];
    end else if (code == shadow_cfg.code_read_first ||
                 code == shadow_cfg.code_read_second) begin
      kind = KIND_SHORT;
      body[4] = shadow_cfg.read_quantity[15:8];
      body[5] = shadow_cfg.read_quantity[7:0];
    end else if (code == shadow_cfg.code_write_single) begin
      kind = KIND_SHORT;
      body[4] = val[15:8];
      body[5] = val[7:0];
    end else begin
      kind = KIND_ERR;
    end
    if (kind == KIND_ERR) begin
      expected_bytes.push_back('{data: 8'h00, last: 1'b1, bad: 1'b1});
      return;
    end
    crc = CRC_INIT;
    for (int k = 0; k < len - 2; k++)
      crc = crc16_update(crc, body[k]);
    // crc goes out high byte first on this link
    body[len - 2] = crc[15:8];
    body[len - 1] = crc[7:0];
    for (int k = 0; k < len; k++)
      expected_bytes.push_back('{data: body[k], last: (k == len - 1), bad: 1'b0});
  endfunction

  // long sink hold-off, started by a test and counted down here
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_OFF_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // frame byte sink: random stalls, held off while a hold-off runs, field checks
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && m_valid && m_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("frame byte with no request pending", {24'd0, m_data}, 32'd0);
      end else begin
        want = expected_bytes.pop_front();
        if (m_data !== want.data)
          report_mismatch("frame_byte", {24'd0, m_data}, {24'd0, want.data});
        if (m_last !== want.last)
          report_mismatch("last", {31'd0, m_last}, {31'd0, want.last});
        if (m_user !== want.bad)
          report_mismatch("bad_code", {31'd0, m_user}, {31'd0, want.bad});
      end
    end
    if (hold_left != 0) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid is left high on return so back-to-back requests need no second drive
  task automatic send_request(logic [7:0] code, logic [7:0] id,
                              logic [15:0] addr, logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= code;
    s_data <= {val, addr, id};
    do @(posedge clk); while (!s_ready);
    predict_frame(code, id, addr, val);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CODE_WRITE_SINGLE: shadow_cfg.code_write_single = val[7:0];
      REG_CODE_WRITE_MULTI:  shadow_cfg.code_write_multi = val[7:0];
      REG_CODE_READ_FIRST:   shadow_cfg.code_read_first = val[7:0];
      REG_CODE_READ_SECOND:  shadow_cfg.code_read_second = val[7:0];
      REG_READ_QUANTITY:     shadow_cfg.read_quantity = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // upper bits of each write carry noise that the block must mask off
  task automatic set_config(logic [7:0] single, logic [7:0] multi, logic [7:0] rd_a,
                            logic [7:0] rd_b, logic [15:0] qty);
    logic [31:0] noise;
    noise = $urandom;
    apb_write(REG_CODE_WRITE_SINGLE, {noise[31:8], single});
    apb_write(REG_CODE_WRITE_MULTI, {noise[30:8], noise[31], multi});
    apb_write(REG_CODE_READ_FIRST, {noise[29:8], noise[31:30], rd_a});
    apb_write(REG_CODE_READ_SECOND, {noise[28:8], noise[31:29], rd_b});
    apb_write(REG_READ_QUANTITY, {noise[31:16], qty});
  endtask

  task automatic test_reset_defaults();
    send_request(shadow_cfg.code_write_single, 8'h00, 16'h0000, 32'h0000_0000);
    send_request(shadow_cfg.code_write_single, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(shadow_cfg.code_read_first, 8'h01, 16'h1234, 32'hDEAD_BEEF);
    send_request(shadow_cfg.code_read_second, 8'h80, 16'h8000, 32'h5555_AAAA);
    send_request(shadow_cfg.code_write_multi, 8'h00, 16'h0000, 32'h0000_0000);
    send_request(shadow_cfg.code_write_multi, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    // unknown codes each give a single error byte
    send_request(CODE_MIN, 8'h11, 16'h0001, 32'h0000_0001);
    send_request(CODE_MAX, 8'h22, 16'h0002, 32'h8000_0000);
    send_request(CODE_UNUSED, 8'h33, 16'h0003, 32'h1234_5678);
    wait_drained();
  endtask

  task automatic test_code_priority();
    // all four codes equal: the write-multi layout wins
    set_config(CODE_SHARED, CODE_SHARED, CODE_SHARED, CODE_SHARED, 16'h0002);
    send_request(CODE_SHARED, 8'h5A, 16'hA55A, 32'h0102_0304);
    wait_drained();
    // read beats write-single
    set_config(CODE_SHARED, CODE_ALT_MULTI, CODE_SHARED, CODE_SHARED, 16'h0002);
    send_request(CODE_SHARED, 8'hA5, 16'h5AA5, 32'h0506_0708);
    send_request(CODE_ALT_MULTI, 8'h01, 16'h0100, 32'hCAFE_F00D);
    wait_drained();
    set_config(CODE_SHARED, CODE_ALT_MULTI, CODE_ALT_READ_A, CODE_ALT_READ_B, 16'h0002);
    send_request(CODE_SHARED, 8'h3C, 16'hC33C, 32'h90AB_CDEF);
    send_request(CODE_ALT_READ_A, 8'h3C, 16'hC33C, 32'h90AB_CDEF);
    send_request(CODE_ALT_READ_B, 8'h3C, 16'hC33C, 32'h90AB_CDEF);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    set_config(CODE_MIN, CODE_MAX, CODE_HIGH_READ, CODE_LOW_READ, 16'h0000);
    send_request(CODE_HIGH_READ, 8'hFE, 16'h7FFF, 32'h0);
    send_request(CODE_MIN, 8'h7F, 16'h8001, 32'h7FFF_8000);
    send_request(CODE_MAX, 8'h80, 16'hFFFE, 32'h8000_7FFF);
    wait_drained();
    apb_write(REG_READ_QUANTITY, 32'h0000_FFFF);
    send_request(CODE_LOW_READ, 8'h01, 16'h0001, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_spare_registers();
    // writes past the register file change nothing
    apb_write(REG_SPARE_A, 32'hFFFF_FFFF);
    apb_write(REG_SPARE_B, 32'h0000_0000);
    apb_write(REG_SPARE_C, 32'hA5A5_A5A5);
    send_request(CODE_LOW_READ, 8'h42, 16'hBEEF, 32'h1111_2222);
    send_request(CODE_MAX, 8'h24, 16'hFEED, 32'h3333_4444);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_requests++;
    // sink stalls while the source keeps offering, queue fills and tready drops
    repeat (8) send_request(shadow_cfg.code_write_multi, 8'($urandom), 16'($urandom),
                            $urandom);
    wait_drained();
  endtask

  task automatic test_random(int unsigned n_items, int unsigned s_pct, int unsigned r_pct);
    logic [7:0]  codes [4];
    logic [15:0] qty;
    logic [7:0]  code;
    logic [15:0] addr;
    logic [31:0] val;
    int unsigned pick;
    for (int blk = 0; blk < 4; blk++) begin
      wait_drained();
      for (int i = 0; i < 4; i++) begin
        codes[i] = 8'($urandom_range(255));
        if ($urandom_range(7) == 0) codes[i] = $urandom_range(1) ? CODE_MAX : CODE_MIN;
        if (i > 0 && $urandom_range(3) == 0) codes[i] = codes[$urandom_range(i - 1)];
      end
      case ($urandom_range(3))
        0: qty = 16'h0000;
        1: qty = 16'hFFFF;
        default: qty = 16'($urandom_range(16'hFFFF));
      endcase
      set_config(codes[0], codes[1], codes[2], codes[3], qty);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (n_items / 4) begin
        pick = $urandom_range(99);
        if (pick < 30) code = shadow_cfg.code_write_multi;
        else if (pick < 50) code = shadow_cfg.code_read_first;
        else if (pick < 65) code = shadow_cfg.code_read_second;
        else if (pick < 85) code = shadow_cfg.code_write_single;
        else code = 8'($urandom_range(255));
        addr = 16'($urandom);
        val = $urandom;
        if ($urandom_range(9) == 0) addr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(9) == 0) val = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        send_request(code, 8'($urandom), addr, val);
      end
    end
    wait_drained();
  endtask

  initial begin
    shadow_cfg = '{code_write_single: 8'd6, code_write_multi: 8'd16,
                   code_read_first: 8'd3, code_read_second: 8'd4, read_quantity: 16'd2};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 53;
    test_reset_defaults();
    test_code_priority();
    test_config_extremes();
    test_spare_registers();
    test_backpressure();

    test_random(144, 22, 53);
    test_random(144, 53, 22);
    test_random(144, 0, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[modbus_request_frame_builder] OK");
    end else begin
      $display("[modbus_request_frame_builder] ERROR");
    end
    $finish;
  end

endmodule
